@@ sv/cbe_pkg.sv @@
// cubic bezier evaluator package: sample index width, config address width
// and register map; no dependencies
package cbe_pkg;

	localparam int INDEX_BITS    = 16;
	localparam int CFG_ADDR_BITS = 3;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_POINT_A = 3'd0,
		CFG_POINT_B = 3'd1,
		CFG_POINT_C = 3'd2,
		CFG_POINT_D = 3'd3,
		CFG_STEP    = 3'd4
	} cfg_reg_t;

endpackage

@@ sv/cubic_bezier_point_evaluator.sv @@
// Cubic Bezier point evaluator, Bernstein form, fixed point
// Uses cbe_pkg for the register map and the sample index width
//
// One result per request, one request accepted every cycle while in_stall is
// low. Stages: index product, clamp, squares, cubes, weight rounding, weight
// times coordinate (twelve multipliers), four-term sum, round and saturate. Every
// stage has its own valid bit, and a stage takes new data when it is empty or
// its successor moves, so bubbles close up and a stall on the output holds
// everything in place without loss. Control points and the step are written
// through the config port (always ready) and must stay fixed while requests
// are in flight.
module cubic_bezier_point_evaluator
	import cbe_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_ADDR_BITS-1:0]              cfg_index,
	input  logic [((3*COORD_BITS > FRAC_BITS+1) ?
		3*COORD_BITS : FRAC_BITS+1)-1:0]          cfg_data,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [INDEX_BITS-1:0]                 sample_index,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [COORD_BITS-1:0]          point_x,
	output logic signed [COORD_BITS-1:0]          point_y,
	output logic signed [COORD_BITS-1:0]          point_z,
	output logic                                  is_last_sample,
	output logic                                  past_end
);

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int PTW = 3 * C;
	localparam int UW  = F + 1;              // u, v, squares
	localparam int PW  = INDEX_BITS + UW;    // index * step
	localparam int MW  = 2 * UW;             // product of two UW values
	localparam int TW  = MW + 2;             // three times a product
	localparam int WW  = F + 2;              // rounded weights
	localparam int PRW = WW + 1 + C;         // weight times coordinate
	localparam int AW  = PRW + 3;            // sum of four terms plus half
	localparam int RW  = AW - F;             // after the shift

	localparam logic [PW-1:0] ONE_P  = PW'(1) << F;
	localparam logic [UW-1:0] ONE_U  = UW'(1) << F;
	localparam logic [MW-1:0] HALF_M = MW'(1) << (F - 1);
	localparam logic [TW-1:0] HALF_T = TW'(1) << (F - 1);
	localparam logic signed [AW-1:0] HALF_A = AW'(1) << (F - 1);
	localparam logic signed [RW-1:0] CMAX_R = RW'((2 ** (C - 1)) - 1);
	localparam logic signed [RW-1:0] CMIN_R = ~CMAX_R;

	// configuration registers
	logic [PTW-1:0] pts_q [4];
	logic [UW-1:0]  step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pts_q[i] <= '0;
			end
			step_q <= ONE_U;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_POINT_A: pts_q[0] <= cfg_data[PTW-1:0];
				CFG_POINT_B: pts_q[1] <= cfg_data[PTW-1:0];
				CFG_POINT_C: pts_q[2] <= cfg_data[PTW-1:0];
				CFG_POINT_D: pts_q[3] <= cfg_data[PTW-1:0];
				CFG_STEP:    step_q   <= cfg_data[UW-1:0];
				default: ;
			endcase
		end
	end

	// pipeline registers
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;

	logic [PW-1:0] prod_s1;
	logic [UW-1:0] step_s1;

	logic [UW-1:0] u_s2, v_s2;
	logic          last_s2, past_s2;

	logic [UW-1:0] u_s3, v_s3, su_s3, sv_s3;
	logic          last_s3, past_s3;

	logic [MW-1:0] m0_s4, m1_s4, m2_s4, m3_s4;
	logic          last_s4, past_s4;

	logic [WW-1:0] w_s5 [4];
	logic          last_s5, past_s5;

	logic signed [PRW-1:0] term_s6 [3][4];
	logic                  last_s6, past_s6;

	logic signed [AW-1:0] sum_s7 [3];
	logic                 last_s7, past_s7;

	logic signed [C-1:0] xyz_s8 [3];
	logic                last_s8, past_s8;

	// a stage loads when it is empty or its content moves on
	assign adv_s8 = !valid_s8 || !out_stall;
	assign adv_s7 = !valid_s7 || adv_s8;
	assign adv_s6 = !valid_s6 || adv_s7;
	assign adv_s5 = !valid_s5 || adv_s6;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
			if (adv_s7) valid_s7 <= valid_s6;
			if (adv_s8) valid_s8 <= valid_s7;
		end
	end

	// combinational stage logic
	logic [PW-1:0] prod_d;
	logic          past_d, last_d;
	logic [UW-1:0] u_d;
	logic [MW-1:0] uu_d, vv_d;
	logic [TW-1:0] t1_d, t2_d;
	logic [WW-1:0] w_d [4];
	logic signed [C-1:0]   coord_d [4][3];
	logic signed [PRW-1:0] term_d [3][4];
	logic signed [AW-1:0]  sum_d [3];
	logic signed [RW-1:0]  r_d [3];
	logic signed [C-1:0]   sat_d [3];

	always_comb begin
		prod_d = PW'(sample_index) * PW'(step_q);

		past_d = prod_s1 > ONE_P;
		last_d = !past_d && ((prod_s1 + PW'(step_s1)) > ONE_P);
		u_d    = past_d ? ONE_U : prod_s1[UW-1:0];

		uu_d = MW'(u_s2) * MW'(u_s2);
		vv_d = MW'(v_s2) * MW'(v_s2);

		// three times the middle products
		t1_d = TW'(m1_s4) + (TW'(m1_s4) << 1);
		t2_d = TW'(m2_s4) + (TW'(m2_s4) << 1);
		w_d[0] = WW'((m0_s4 + HALF_M) >> F);
		w_d[1] = WW'((t1_d + HALF_T) >> F);
		w_d[2] = WW'((t2_d + HALF_T) >> F);
		w_d[3] = WW'((m3_s4 + HALF_M) >> F);

		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 3; k++) begin
				coord_d[j][k] = signed'(pts_q[j][k*C +: C]);
			end
		end
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 4; j++) begin
				term_d[k][j] = signed'({1'b0, w_s5[j]}) * PRW'(coord_d[j][k]);
			end
		end

		for (int k = 0; k < 3; k++) begin
			sum_d[k] = AW'(term_s6[k][0]) + AW'(term_s6[k][1])
				+ AW'(term_s6[k][2]) + AW'(term_s6[k][3]) + HALF_A;
		end

		// arithmetic shift gives the floor, then clamp to the coordinate range
		for (int k = 0; k < 3; k++) begin
			r_d[k] = RW'(sum_s7[k] >>> F);
			if (r_d[k] > CMAX_R) begin
				sat_d[k] = C'(CMAX_R);
			end else if (r_d[k] < CMIN_R) begin
				sat_d[k] = C'(CMIN_R);
			end else begin
				sat_d[k] = C'(r_d[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prod_s1 <= prod_d;
			step_s1 <= step_q;
		end
		if (adv_s2) begin
			u_s2    <= u_d;
			v_s2    <= ONE_U - u_d;
			past_s2 <= past_d;
			last_s2 <= last_d;
		end
		if (adv_s3) begin
			u_s3    <= u_s2;
			v_s3    <= v_s2;
			su_s3   <= UW'((uu_d + HALF_M) >> F);
			sv_s3   <= UW'((vv_d + HALF_M) >> F);
			past_s3 <= past_s2;
			last_s3 <= last_s2;
		end
		if (adv_s4) begin
			m0_s4   <= MW'(sv_s3) * MW'(v_s3);
			m1_s4   <= MW'(u_s3) * MW'(sv_s3);
			m2_s4   <= MW'(su_s3) * MW'(v_s3);
			m3_s4   <= MW'(su_s3) * MW'(u_s3);
			past_s4 <= past_s3;
			last_s4 <= last_s3;
		end
		if (adv_s5) begin
			for (int j = 0; j < 4; j++) begin
				w_s5[j] <= w_d[j];
			end
			past_s5 <= past_s4;
			last_s5 <= last_s4;
		end
		if (adv_s6) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 4; j++) begin
					term_s6[k][j] <= term_d[k][j];
				end
			end
			past_s6 <= past_s5;
			last_s6 <= last_s5;
		end
		if (adv_s7) begin
			for (int k = 0; k < 3; k++) begin
				sum_s7[k] <= sum_d[k];
			end
			past_s7 <= past_s6;
			last_s7 <= last_s6;
		end
		if (adv_s8) begin
			for (int k = 0; k < 3; k++) begin
				xyz_s8[k] <= sat_d[k];
			end
			past_s8 <= past_s7;
			last_s8 <= last_s7;
		end
	end

	assign out_valid      = valid_s8;
	assign point_x        = xyz_s8[0];
	assign point_y        = xyz_s8[1];
	assign point_z        = xyz_s8[2];
	assign is_last_sample = last_s8;
	assign past_end       = past_s8;

	// the two flags exclude each other
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_last_sample && past_end))
		else $error("last and past-end flags both set");

	// a clamped parameter lands exactly on the fourth control point
	a_past_end_is_d: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && past_end) |->
			(point_x == pts_q[3][C-1:0]) && (point_y == pts_q[3][2*C-1:C])
			&& (point_z == pts_q[3][3*C-1:2*C]))
		else $error("clamped result differs from the end point");

	// a zero step never reaches the end of the curve
	a_zero_step_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (step_q == '0)) |-> (!past_end && !is_last_sample))
		else $error("flag set with zero step");

	// back-pressure only reaches the input when every stage is occupied and the output stalls
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s8 && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule

@@ sim/cubic_bezier_point_evaluator_tb.sv @@
// testbench for cubic_bezier_point_evaluator: self-checking, with its own fixed-point
// Bernstein predictor, random idling on both channels and config changes between runs
// depends on cbe_pkg and the evaluator RTL
module cubic_bezier_point_evaluator_tb;
	import cbe_pkg::*;

	localparam int COORD_BITS    = 16;
	localparam int FRAC_BITS     = 16;
	localparam int CFG_DATA_BITS = 3 * COORD_BITS;
	localparam longint unsigned ONE_Q  = 64'd1 << FRAC_BITS;
	localparam longint unsigned HALF_Q = 64'd1 << (FRAC_BITS - 1);
	localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int BATCH_ITEMS   = 113;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic                         last;
		logic                         past;
	} bezier_point_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_ADDR_BITS-1:0]     cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [INDEX_BITS-1:0]        sample_index = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic                         is_last_sample;
	logic                         past_end;

	// local copy of the register file
	logic [CFG_DATA_BITS-1:0] ctrl_pts [4];
	logic [FRAC_BITS:0]       step_q = 17'h10000;

	logic [INDEX_BITS-1:0] index_queue [$];
	bezier_point_t         predicted_points [$];
	bezier_point_t         head;
	int                    send_gap_pct = 31;
	int                    stall_pct = 57;
	int                    errors = 0;
	int                    cycles = 0;

	cubic_bezier_point_evaluator #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_index  (sample_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.is_last_sample(is_last_sample),
		.past_end      (past_end)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint unsigned rnd_q(longint unsigned t);
		return (t + HALF_Q) >> FRAC_BITS;
	endfunction

	function automatic longint coord_at(logic [CFG_DATA_BITS-1:0] pt, int k);
		logic signed [COORD_BITS-1:0] c;
		c = pt[k*COORD_BITS +: COORD_BITS];
		return c;
	endfunction

	function automatic bezier_point_t bezier_at(logic [INDEX_BITS-1:0] idx);
		longint unsigned s, p, u, v, su, sv;
		longint          w0, w1, w2, w3, acc, r;
		logic signed [COORD_BITS-1:0] res [3];
		bezier_point_t   pt;
		s = step_q;
		p = longint'(idx) * s;
		pt.past = p > ONE_Q;
		pt.last = !pt.past && (p + s) > ONE_Q;
		u = pt.past ? ONE_Q : p;
		v = ONE_Q - u;
		su = rnd_q(u * u);
		sv = rnd_q(v * v);
		w0 = longint'(rnd_q(sv * v));
		w1 = longint'(rnd_q(3 * u * sv));
		w2 = longint'(rnd_q(3 * su * v));
		w3 = longint'(rnd_q(su * u));
		for (int k = 0; k < 3; k++) begin
			acc = w0 * coord_at(ctrl_pts[0], k) + w1 * coord_at(ctrl_pts[1], k)
				+ w2 * coord_at(ctrl_pts[2], k) + w3 * coord_at(ctrl_pts[3], k);
			// arithmetic shift floors, so halves go toward plus infinity
			r = (acc + longint'(HALF_Q)) >>> FRAC_BITS;
			if (r > COORD_MAX) r = COORD_MAX;
			if (r < COORD_MIN) r = COORD_MIN;
			res[k] = r[COORD_BITS-1:0];
		end
		pt.x = res[0];
		pt.y = res[1];
		pt.z = res[2];
		return pt;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predicted_points.insert(predicted_points.size(), bezier_at(sample_index));
			if (!in_valid || !in_stall) begin
				if (index_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					sample_index <= index_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_points.size() == 0) begin
					$display("%0t: unexpected result, expected none, got x=%0d y=%0d z=%0d",
						$time, point_x, point_y, point_z);
					errors++;
				end else begin
					head = predicted_points.pop_front();
					check_field("point_x", head.x, point_x);
					check_field("point_y", head.y, point_y);
					check_field("point_z", head.z, point_z);
					check_field("is_last_sample", head.last, is_last_sample);
					check_field("past_end", head.past, past_end);
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, predicted_points.size());
			$display("cubic_bezier_point_evaluator_tb failed");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_STEP)
			step_q = val[FRAC_BITS:0];
		else
			ctrl_pts[idx] = val;
	endtask

	task automatic write_config(logic [CFG_DATA_BITS-1:0] a, logic [CFG_DATA_BITS-1:0] b,
		logic [CFG_DATA_BITS-1:0] c, logic [CFG_DATA_BITS-1:0] d,
		logic [CFG_DATA_BITS-1:0] step);
		write_reg(CFG_POINT_A, a);
		write_reg(CFG_POINT_B, b);
		write_reg(CFG_POINT_C, c);
		write_reg(CFG_POINT_D, d);
		write_reg(CFG_STEP, step);
	endtask

	// wait until every request is answered and the pipeline has emptied
	task automatic drain();
		while (index_queue.size() != 0 || in_valid || predicted_points.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] rand_point();
		return {rand_coord(), rand_coord(), rand_coord()};
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] rand_step();
		case ($urandom_range(0, 9))
			0: return CFG_DATA_BITS'(1);
			1: return CFG_DATA_BITS'(ONE_Q);
			2: return '0;
			3: return CFG_DATA_BITS'(ONE_Q / $urandom_range(2, 64));
			4: return CFG_DATA_BITS'($urandom_range(ONE_Q + 1, 2 * ONE_Q - 1));
			8: return CFG_DATA_BITS'($urandom_range(1, ONE_Q));
			// upper bits beyond the step field are dropped by the block
			9: return CFG_DATA_BITS'({$urandom, $urandom});
			default: return CFG_DATA_BITS'(ONE_Q / $urandom_range(2, 2000));
		endcase
	endfunction

	// most indexes fall inside the curve, with extra weight around its end
	function automatic logic [INDEX_BITS-1:0] pick_index();
		int last_idx;
		int pick;
		last_idx = (step_q == 0) ? 65535 : int'(ONE_Q / step_q) + 2;
		if (last_idx > 65535) last_idx = 65535;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return INDEX_BITS'($urandom_range(0, last_idx));
		else if (pick < 75)
			return INDEX_BITS'((last_idx > 4) ? last_idx - int'($urandom_range(0, 4))
				: last_idx);
		else
			return INDEX_BITS'($urandom_range(0, 65535));
	endfunction

	task automatic random_batches(int n);
		for (int b = 0; b < n; b++) begin
			drain();
			write_config(rand_point(), rand_point(), rand_point(), rand_point(), rand_step());
			for (int i = 0; i < BATCH_ITEMS; i++)
				index_queue.insert(index_queue.size(), pick_index());
		end
	endtask

	initial begin
		for (int i = 0; i < 4; i++) ctrl_pts[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: all points zero, one step spans the curve
		index_queue = '{16'd0, 16'd1, 16'd2, 16'd65535};
		drain();
		// identical extreme points, rounded weights may overshoot and saturate
		write_config({16'h8000, 16'h7fff, 16'h7fff}, {16'h8000, 16'h7fff, 16'h7fff},
			{16'h8000, 16'h7fff, 16'h7fff}, {16'h8000, 16'h7fff, 16'h7fff},
			CFG_DATA_BITS'(21846));
		index_queue = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535};
		drain();
		// zero step pins every sample to the first point
		write_config({16'h1234, 16'h8000, 16'h7fff}, {16'h7fff, 16'h0001, 16'hffff},
			{16'h8000, 16'h8000, 16'h8000}, {16'h5555, 16'haaaa, 16'h0f0f}, '0);
		index_queue = '{16'd0, 16'd65535, 16'd40000};
		drain();
		// step above one
		write_reg(CFG_STEP, CFG_DATA_BITS'(17'h1ffff));
		index_queue = '{16'd0, 16'd1, 16'd65535};
		drain();
		// smallest step, the top index stays inside the curve
		write_config({16'hffff, 16'h0000, 16'h7fff}, {16'h8000, 16'h7fff, 16'h0000},
			{16'h0000, 16'h8000, 16'hffff}, {16'h7fff, 16'hffff, 16'h8000},
			CFG_DATA_BITS'(1));
		index_queue = '{16'd0, 16'd1, 16'd65535};

		random_batches(5);
		drain();
		send_gap_pct = 57;
		stall_pct = 31;
		random_batches(5);
		drain();
		send_gap_pct = 0;
		stall_pct = 0;
		random_batches(5);
		drain();

		if (errors == 0) begin
			$display("cubic_bezier_point_evaluator_tb passed");
		end else begin
			$display("cubic_bezier_point_evaluator_tb failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/cbe_pkg.sv
sv/cubic_bezier_point_evaluator.sv
sim/cubic_bezier_point_evaluator_tb.sv
